/* hdl/jtok_pkg.sv */
// Shared types and codes for the JSON tokenizer.
// Used by jtok_front, jtok_queue, jtok_back and json_tokenizer_top.
package jtok_pkg;

    localparam int WORD_MAX = 8;  // largest word buffer the design supports
    localparam int FLUSH_W  = 4;
    localparam int MAX_RES  = 7;

    localparam logic [1:0] KIND_CONTENT = 2'd0;
    localparam logic [1:0] KIND_TOKEN   = 2'd1;
    localparam logic [1:0] KIND_NOTE    = 2'd2;
    localparam logic [1:0] KIND_VERDICT = 2'd3;

    localparam logic [3:0] TOK_LBRACE  = 4'd0;
    localparam logic [3:0] TOK_RBRACE  = 4'd1;
    localparam logic [3:0] TOK_LBRACK  = 4'd2;
    localparam logic [3:0] TOK_RBRACK  = 4'd3;
    localparam logic [3:0] TOK_COMMA   = 4'd4;
    localparam logic [3:0] TOK_COLON   = 4'd5;
    localparam logic [3:0] TOK_TRUE    = 4'd6;
    localparam logic [3:0] TOK_FALSE   = 4'd7;
    localparam logic [3:0] TOK_NULL    = 4'd8;
    localparam logic [3:0] TOK_NUMBER  = 4'd9;
    localparam logic [3:0] TOK_STRING  = 4'd10;
    localparam logic [3:0] TOK_UNKNOWN = 4'd11;

    localparam logic [2:0] NOTE_UNEXPECTED = 3'd0;
    localparam logic [2:0] NOTE_CONTROL    = 3'd1;
    localparam logic [2:0] NOTE_ESCAPE     = 3'd2;
    localparam logic [2:0] NOTE_HEX        = 3'd3;
    localparam logic [2:0] NOTE_EXPONENT   = 3'd4;
    localparam logic [2:0] NOTE_COMMENT    = 3'd5;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] tok;
        logic [7:0] byte_val;
        logic [2:0] note;
        logic       fatal;
        logic       ok;
    } t_res;

    // One accepted byte's work: flushed word bytes first, then up to two results.
    typedef struct packed {
        logic [WORD_MAX-1:0][7:0] word;
        logic [FLUSH_W-1:0]       flush_n;
        logic                     r0_v;
        logic                     r1_v;
        t_res                     r0;
        t_res                     r1;
    } t_cmd;

    function automatic t_res mk_res(logic [1:0] kind, logic [3:0] tok, logic [7:0] b,
                                    logic [2:0] note, logic fatal, logic ok);
        t_res r;
        r.kind     = kind;
        r.tok      = tok;
        r.byte_val = b;
        r.note     = note;
        r.fatal    = fatal;
        r.ok       = ok;
        return r;
    endfunction

endpackage

/* hdl/jtok_queue.sv */
// Short command queue between the lexer front and the result back end.
// Depends on jtok_pkg.
module jtok_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jtok_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output jtok_pkg::t_cmd o_cmd
);
    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    jtok_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [AW:0]    r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end
endmodule

/* hdl/jtok_front.sv */
// Lexer front end: classifies each text byte and emits at most one queue command.
// Depends on jtok_pkg.
module jtok_front #(
    parameter int KEYWORD_BUF = 5
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic           i_cfg_bit,
    input  logic           i_take,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    output logic           o_push,
    output jtok_pkg::t_cmd o_cmd
);
    localparam int LW = $clog2(KEYWORD_BUF + 1);
    localparam int IW = $clog2(KEYWORD_BUF);

    typedef enum logic [4:0] {
        S_IDLE = 5'd0, S_STR = 5'd1, S_ESC = 5'd2, S_HEX0 = 5'd3, S_HEX1 = 5'd4,
        S_HEX2 = 5'd5, S_HEX3 = 5'd6, S_INT = 5'd7, S_FRAC = 5'd8, S_EXPS = 5'd9,
        S_EXPD = 5'd10, S_WORD = 5'd11, S_SLASH = 5'd12, S_LCOM = 5'd13,
        S_BCOM = 5'd14, S_BSTAR = 5'd15, S_SSTR = 5'd16, S_SESC = 5'd17,
        S_SHEX0 = 5'd18, S_SHEX1 = 5'd19, S_SHEX2 = 5'd20, S_SHEX3 = 5'd21
    } t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_wlen, n_wlen;
    logic          r_halt, r_perm;
    logic [7:0]    r_word [KEYWORD_BUF];
    logic          w_we;
    logic [IW-1:0] w_widx;

    logic [7:0] c;
    assign c = i_byte;

    function automatic logic is_digit(logic [7:0] x);
        return x >= "0" && x <= "9";
    endfunction
    function automatic logic is_alpha(logic [7:0] x);
        return (x >= "a" && x <= "z") || (x >= "A" && x <= "Z");
    endfunction
    function automatic logic is_hexd(logic [7:0] x);
        return is_digit(x) || (x >= "a" && x <= "f") || (x >= "A" && x <= "F");
    endfunction

    // Idle-state lexing of one byte; shared by idle and by reprocessed terminators.
    logic         id_v, id_wstart;
    jtok_pkg::t_res id_r;
    t_state       id_st;
    always_comb begin
        id_v      = 1'b0;
        id_wstart = 1'b0;
        id_st     = S_IDLE;
        id_r      = jtok_pkg::mk_res(jtok_pkg::KIND_TOKEN, 4'd0, 8'd0, 3'd0, 1'b0, 1'b0);
        priority if (c == "{") begin
            id_v = 1'b1; id_r.tok = jtok_pkg::TOK_LBRACE;
        end else if (c == "}") begin
            id_v = 1'b1; id_r.tok = jtok_pkg::TOK_RBRACE;
        end else if (c == "[") begin
            id_v = 1'b1; id_r.tok = jtok_pkg::TOK_LBRACK;
        end else if (c == "]") begin
            id_v = 1'b1; id_r.tok = jtok_pkg::TOK_RBRACK;
        end else if (c == ",") begin
            id_v = 1'b1; id_r.tok = jtok_pkg::TOK_COMMA;
        end else if (c == ":") begin
            id_v = 1'b1; id_r.tok = jtok_pkg::TOK_COLON;
        end else if (c == "\"") begin
            id_st = S_STR;
        end else if (c == "-" || is_digit(c)) begin
            id_v  = 1'b1;
            id_r  = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c, 3'd0, 1'b0, 1'b0);
            id_st = S_INT;
        end else if (is_alpha(c)) begin
            id_wstart = 1'b1;
            id_st     = S_WORD;
        end else if (r_perm && c == "/") begin
            id_st = S_SLASH;
        end else if (r_perm && c == "'") begin
            id_st = S_SSTR;
        end else begin
            // drop white space, flag anything else
            id_v = !(c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09);
            id_r = jtok_pkg::mk_res(jtok_pkg::KIND_NOTE, 4'd0, 8'd0,
                                    jtok_pkg::NOTE_UNEXPECTED, 1'b1, 1'b0);
        end
    end

    function automatic logic word_is(logic [LW-1:0] wl, logic [7:0] w [KEYWORD_BUF],
                                     logic [39:0] kw, int len);
        logic m;
        m = (wl == LW'(len));
        for (int i = 0; i < 5; i++) begin
            if (i < len && w[i] != kw[8*(len-1-i) +: 8]) m = 1'b0;
        end
        return m;
    endfunction

    jtok_pkg::t_cmd cmd;
    logic           is_end, is_ctl;
    t_state         base_st, hex_last;

    always_comb begin
        is_end = i_end || (c == 8'd0);
        is_ctl = (c <= 8'h1f) || (c == 8'h7f);
        cmd    = '0;
        for (int i = 0; i < KEYWORD_BUF; i++) begin
            cmd.word[i] = r_word[i];
        end
        n_state = r_state;
        n_wlen  = r_wlen;
        w_we    = 1'b0;
        w_widx  = '0;
        base_st  = (r_state >= S_SSTR) ? S_SSTR : S_STR;
        hex_last = (r_state >= S_SSTR) ? S_SHEX3 : S_HEX3;

        if (is_end) begin
            cmd.r0_v = 1'b1;
            cmd.r0   = jtok_pkg::mk_res(jtok_pkg::KIND_VERDICT, 4'd0, 8'd0, 3'd0, 1'b0,
                                        !r_halt && (r_state == S_IDLE || r_state == S_LCOM));
            n_state  = S_IDLE;
            n_wlen   = '0;
        end else if (!r_halt) begin
            unique case (r_state)
                S_STR, S_SSTR: begin
                    if (c == ((r_state == S_STR) ? 8'h22 : 8'h27)) begin
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_TOKEN,
                                     jtok_pkg::TOK_STRING, 8'd0, 3'd0, 1'b0, 1'b0);
                        n_state = S_IDLE;
                    end else if (c == 8'h5c) begin
                        n_state = t_state'(r_state + 5'd1);
                    end else if (is_ctl) begin
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_NOTE, 4'd0, 8'd0,
                                     jtok_pkg::NOTE_CONTROL, 1'b1, 1'b0);
                    end else begin
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                     3'd0, 1'b0, 1'b0);
                    end
                end
                S_ESC, S_SESC: begin
                    n_state  = base_st;
                    cmd.r0_v = 1'b1;
                    cmd.r0   = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                   3'd0, 1'b0, 1'b0);
                    priority case (c)
                        8'h22, 8'h5c, 8'h2f: ;
                        "b": cmd.r0.byte_val = 8'd8;
                        "f": cmd.r0.byte_val = 8'd12;
                        "n": cmd.r0.byte_val = 8'd10;
                        "r": cmd.r0.byte_val = 8'd13;
                        "t": cmd.r0.byte_val = 8'd9;
                        "u": begin
                            cmd.r0_v = 1'b0;
                            n_state  = t_state'(r_state + 5'd1);
                        end
                        default: cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_NOTE, 4'd0,
                                     8'd0, jtok_pkg::NOTE_ESCAPE, 1'b0, 1'b0);
                    endcase
                end
                S_HEX0, S_HEX1, S_HEX2, S_HEX3, S_SHEX0, S_SHEX1, S_SHEX2, S_SHEX3: begin
                    cmd.r0_v = 1'b1;
                    if (is_hexd(c)) begin
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                     3'd0, 1'b0, 1'b0);
                        n_state = (r_state == hex_last) ? base_st
                                                        : t_state'(r_state + 5'd1);
                    end else begin
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_NOTE, 4'd0, 8'd0,
                                     jtok_pkg::NOTE_HEX, 1'b0, 1'b0);
                        n_state = base_st;
                    end
                end
                S_INT, S_FRAC, S_EXPD: begin
                    if (is_digit(c) || (r_state == S_INT && c == ".")
                        || (r_state == S_FRAC && (c == "e" || c == "E"))) begin
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                     3'd0, 1'b0, 1'b0);
                        if (!is_digit(c)) n_state = t_state'(r_state + 5'd1);
                    end else begin
                        // close the number, then lex the terminator from idle
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_TOKEN,
                                     jtok_pkg::TOK_NUMBER, 8'd0, 3'd0, 1'b0, 1'b0);
                        cmd.r1_v = id_v;
                        cmd.r1   = id_r;
                        n_state  = id_st;
                        if (id_wstart) begin
                            w_we = 1'b1; n_wlen = LW'(1);
                        end
                    end
                end
                S_EXPS: begin
                    cmd.r0_v = 1'b1;
                    if (is_digit(c) || c == "-" || c == "+") begin
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                     3'd0, 1'b0, 1'b0);
                        n_state = S_EXPD;
                    end else begin
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_NOTE, 4'd0, 8'd0,
                                     jtok_pkg::NOTE_EXPONENT, 1'b0, 1'b0);
                        n_state = S_IDLE;
                    end
                end
                S_WORD: begin
                    if (is_alpha(c)) begin
                        if (r_wlen == '0) begin
                            cmd.r0_v = 1'b1;
                            cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                         3'd0, 1'b0, 1'b0);
                        end else if (r_wlen < LW'(KEYWORD_BUF)) begin
                            w_we   = 1'b1;
                            w_widx = r_wlen[IW-1:0];
                            n_wlen = r_wlen + 1'b1;
                        end else begin
                            // buffer full: flush it and stream the rest as content
                            cmd.flush_n = jtok_pkg::FLUSH_W'(r_wlen);
                            cmd.r0_v = 1'b1;
                            cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0, c,
                                         3'd0, 1'b0, 1'b0);
                            n_wlen = '0;
                        end
                    end else begin
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_TOKEN,
                                     jtok_pkg::TOK_UNKNOWN, 8'd0, 3'd0, 1'b0, 1'b0);
                        priority if (word_is(r_wlen, r_word, 40'h0074727565, 4)) begin
                            cmd.r0.tok = jtok_pkg::TOK_TRUE;
                        end else if (word_is(r_wlen, r_word, 40'h66616c7365, 5)) begin
                            cmd.r0.tok = jtok_pkg::TOK_FALSE;
                        end else if (word_is(r_wlen, r_word, 40'h006e756c6c, 4)) begin
                            cmd.r0.tok = jtok_pkg::TOK_NULL;
                        end else begin
                            cmd.flush_n = jtok_pkg::FLUSH_W'(r_wlen);
                        end
                        cmd.r1_v = id_v;
                        cmd.r1   = id_r;
                        n_state  = id_st;
                        n_wlen   = '0;
                        if (id_wstart) begin
                            w_we = 1'b1; n_wlen = LW'(1);
                        end
                    end
                end
                S_SLASH: begin
                    if (c == "/") n_state = S_LCOM;
                    else if (c == "*") n_state = S_BCOM;
                    else begin
                        cmd.r0_v = 1'b1;
                        cmd.r0 = jtok_pkg::mk_res(jtok_pkg::KIND_NOTE, 4'd0, 8'd0,
                                     jtok_pkg::NOTE_COMMENT, 1'b1, 1'b0);
                    end
                end
                S_LCOM: if (c == 8'h0a || c == 8'h0d) n_state = S_IDLE;
                S_BCOM: if (c == "*") n_state = S_BSTAR;
                S_BSTAR: begin
                    if (c == "/") n_state = S_IDLE;
                    else if (c != "*") n_state = S_BCOM;
                end
                default: begin
                    cmd.r0_v = id_v;
                    cmd.r0   = id_r;
                    n_state  = id_st;
                    if (id_wstart) begin
                        w_we = 1'b1; n_wlen = LW'(1);
                    end
                end
            endcase
        end
    end

    assign o_cmd  = cmd;
    assign o_push = i_take && (cmd.r0_v || cmd.flush_n != '0);

    always_ff @(posedge i_clk) begin
        if (i_take && !is_end && !r_halt && w_we) begin
            r_word[w_widx] <= c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wlen  <= '0;
            r_halt  <= 1'b0;
            r_perm  <= 1'b0;
        end else begin
            if (i_cfg_we) r_perm <= i_cfg_bit;
            if (i_take) begin
                r_state <= n_state;
                r_wlen  <= n_wlen;
                if (is_end) r_halt <= 1'b0;
                else if ((cmd.r0_v && cmd.r0.kind == jtok_pkg::KIND_NOTE && cmd.r0.fatal)
                      || (cmd.r1_v && cmd.r1.kind == jtok_pkg::KIND_NOTE && cmd.r1.fatal))
                    r_halt <= 1'b1;
            end
        end
    end
endmodule

/* hdl/jtok_back.sv */
// Result back end: expands one queue command into result beats.
// Depends on jtok_pkg.
module jtok_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  jtok_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output jtok_pkg::t_res o_res,
    output logic           o_last
);
    logic [jtok_pkg::FLUSH_W-1:0] r_idx, total;
    logic                         load, last;
    jtok_pkg::t_res               cur;
    jtok_pkg::t_res               r_res;
    logic                         r_valid, r_last;

    always_comb begin
        total = i_cmd.flush_n + jtok_pkg::FLUSH_W'(i_cmd.r0_v)
              + jtok_pkg::FLUSH_W'(i_cmd.r1_v);
        cur = jtok_pkg::mk_res(jtok_pkg::KIND_CONTENT, 4'd0,
                               i_cmd.word[r_idx[$clog2(jtok_pkg::WORD_MAX)-1:0]],
                               3'd0, 1'b0, 1'b0);
        if (r_idx == i_cmd.flush_n) cur = i_cmd.r0;
        else if (r_idx > i_cmd.flush_n) cur = i_cmd.r1;
        // drop anything past the result limit
        last = (r_idx == total - 1'b1)
            || (r_idx == jtok_pkg::FLUSH_W'(jtok_pkg::MAX_RES - 1));
    end

    assign load    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = load && last;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= cur;
            r_last <= last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end
endmodule

/* hdl/json_tokenizer_top.sv */
// JSON tokenizer: takes one text byte per beat (tlast = end of text) and
// streams results (tuser = result kind, tlast = last result of that byte).
// A byte is taken every cycle while the four-entry command queue has room;
// each byte makes at most one queue command, and the result port drains one
// result per cycle when ready; a byte ending a long word yields up to seven results.
// The single configuration bit enables comments and single-quoted strings.
module json_tokenizer_top #(
    parameter int KEYWORD_BUF = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // token_type[3:0], content_byte[11:4], note_code[14:12], fatal[15], text_ok[16]
    output logic [23:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // result_kind
    output logic        m_axis_tlast    // last_result
);
    logic           full, empty, push, pop, take;
    jtok_pkg::t_cmd wcmd, rcmd;
    jtok_pkg::t_res res;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !full;
    assign take          = s_axis_tvalid && !full;

    jtok_front #(.KEYWORD_BUF(KEYWORD_BUF)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_valid), .i_cfg_bit(i_cfg_data),
        .i_take(take), .i_byte(s_axis_tdata), .i_end(s_axis_tlast),
        .o_push(push), .o_cmd(wcmd)
    );

    jtok_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_cmd(wcmd), .o_full(full),
        .i_pop(pop), .o_empty(empty), .o_cmd(rcmd)
    );

    jtok_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_empty(empty), .i_cmd(rcmd), .o_pop(pop),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_res(res), .o_last(m_axis_tlast)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {7'd0, res.ok, res.fatal, res.note, res.byte_val, res.tok};
endmodule

/* verif/tb.sv */
// Testbench for json_tokenizer_top: drives text bytes and config writes,
// checks each output beat against a behavioral lexer held in a scoreboard class.
// Depends on jtok_pkg for result kinds, token and note codes.
`timescale 1ns / 100ps

module tb;

    localparam int KW_LEN = 5;

    typedef enum logic [4:0] {
        LX_IDLE = 5'd0, LX_DSTR = 5'd1, LX_DESC = 5'd2, LX_DHEX0 = 5'd3,
        LX_DHEX3 = 5'd6, LX_INT = 5'd7, LX_FRAC = 5'd8, LX_EXPS = 5'd9,
        LX_EXPD = 5'd10, LX_WORD = 5'd11, LX_SLASH = 5'd12, LX_LINE = 5'd13,
        LX_BLOCK = 5'd14, LX_STAR = 5'd15, LX_SSTR = 5'd16, LX_SESC = 5'd17,
        LX_SHEX0 = 5'd18, LX_SHEX3 = 5'd21
    } lex_state_e;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] tok;
        logic [7:0] byte_val;
        logic [2:0] note;
        logic       fatal;
        logic       ok;
        logic       last;
    } tok_beat_t;

    class lexer_scoreboard;
        bit         permissive;
        logic [4:0] st;
        logic [7:0] wbuf [KW_LEN];
        int         wlen;
        bit         halted;
        tok_beat_t  step_q[$];
        tok_beat_t  pending_q[$];
        int         errors;

        function void clear();
            st = LX_IDLE; wlen = 0; halted = 0;
        endfunction

        function void put(logic [1:0] k, logic [3:0] t, logic [7:0] b,
                          logic [2:0] n, logic f, logic o);
            tok_beat_t r;
            if (step_q.size() >= jtok_pkg::MAX_RES) return;
            r = '{k, t, b, n, f, o, 1'b0};
            step_q.push_back(r);
        endfunction

        function void content(logic [7:0] b);
            put(jtok_pkg::KIND_CONTENT, 0, b, 0, 0, 0);
        endfunction
        function void token(logic [3:0] t); put(jtok_pkg::KIND_TOKEN, t, 0, 0, 0, 0); endfunction
        function void note(logic [2:0] n, logic f);
            put(jtok_pkg::KIND_NOTE, 0, 0, n, f, 0);
            if (f) halted = 1;
        endfunction

        function bit is_dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction
        function bit is_hex(logic [7:0] c);
            return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
        endfunction

        function bit word_eq(string kw);
            if (wlen != kw.len()) return 0;
            for (int i = 0; i < wlen; i++) if (wbuf[i] != kw[i]) return 0;
            return 1;
        endfunction

        function void flush_word();
            for (int i = 0; i < wlen; i++) content(wbuf[i]);
            wlen = 0;
        endfunction

        function void idle(logic [7:0] c);
            st = LX_IDLE;
            case (c)
                "{": token(jtok_pkg::TOK_LBRACE);
                "}": token(jtok_pkg::TOK_RBRACE);
                "[": token(jtok_pkg::TOK_LBRACK);
                "]": token(jtok_pkg::TOK_RBRACK);
                ",": token(jtok_pkg::TOK_COMMA);
                ":": token(jtok_pkg::TOK_COLON);
                "\"": st = LX_DSTR;
                default: begin
                    if (c == "-" || is_dig(c)) begin
                        content(c); st = LX_INT;
                    end else if (is_alpha(c)) begin
                        wbuf[0] = c; wlen = 1; st = LX_WORD;
                    end else if (permissive && c == "/") begin
                        st = LX_SLASH;
                    end else if (permissive && c == 8'h27) begin
                        st = LX_SSTR;
                    end else if (!(c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09)) begin
                        note(jtok_pkg::NOTE_UNEXPECTED, 1);
                    end
                end
            endcase
        endfunction

        function void end_number(logic [7:0] c);
            token(jtok_pkg::TOK_NUMBER); idle(c);
        endfunction

        function void lex(logic [7:0] c);
            logic [4:0] base;
            case (st)
                LX_DSTR, LX_SSTR: begin
                    if (c == ((st == LX_DSTR) ? 8'h22 : 8'h27)) begin
                        token(jtok_pkg::TOK_STRING); st = LX_IDLE;
                    end else if (c == "\\") st = st + 1;
                    else if (c <= 8'h1f || c == 8'h7f) note(jtok_pkg::NOTE_CONTROL, 1);
                    else content(c);
                end
                LX_DESC, LX_SESC: begin
                    base = st - 1;
                    st = base;
                    case (c)
                        "\"", "\\", "/": content(c);
                        "b": content(8'd8);
                        "f": content(8'd12);
                        "n": content(8'd10);
                        "r": content(8'd13);
                        "t": content(8'd9);
                        "u": st = base + 2;
                        default: note(jtok_pkg::NOTE_ESCAPE, 0);
                    endcase
                end
                5'd3, 5'd4, 5'd5, 5'd6, 5'd18, 5'd19, 5'd20, 5'd21: begin
                    base = (st <= LX_DHEX3) ? LX_DSTR : LX_SSTR;
                    if (is_hex(c)) begin
                        content(c);
                        st = (st == LX_DHEX3 || st == LX_SHEX3) ? base : st + 1;
                    end else begin
                        note(jtok_pkg::NOTE_HEX, 0); st = base;
                    end
                end
                LX_INT: begin
                    if (is_dig(c)) content(c);
                    else if (c == ".") begin content(c); st = LX_FRAC; end
                    else end_number(c);
                end
                LX_FRAC: begin
                    if (is_dig(c)) content(c);
                    else if (c == "e" || c == "E") begin content(c); st = LX_EXPS; end
                    else end_number(c);
                end
                LX_EXPS: begin
                    if (is_dig(c) || c == "-" || c == "+") begin content(c); st = LX_EXPD; end
                    else begin note(jtok_pkg::NOTE_EXPONENT, 0); st = LX_IDLE; end
                end
                LX_EXPD: begin
                    if (is_dig(c)) content(c);
                    else end_number(c);
                end
                LX_WORD: begin
                    if (is_alpha(c)) begin
                        if (wlen == 0) content(c);
                        else if (wlen < KW_LEN) begin wbuf[wlen] = c; wlen++; end
                        else begin flush_word(); content(c); end
                    end else begin
                        if (word_eq("true")) token(jtok_pkg::TOK_TRUE);
                        else if (word_eq("false")) token(jtok_pkg::TOK_FALSE);
                        else if (word_eq("null")) token(jtok_pkg::TOK_NULL);
                        else begin flush_word(); token(jtok_pkg::TOK_UNKNOWN); end
                        wlen = 0;
                        idle(c);
                    end
                end
                LX_SLASH: begin
                    if (c == "/") st = LX_LINE;
                    else if (c == "*") st = LX_BLOCK;
                    else note(jtok_pkg::NOTE_COMMENT, 1);
                end
                LX_LINE: if (c == 8'h0a || c == 8'h0d) st = LX_IDLE;
                LX_BLOCK: if (c == "*") st = LX_STAR;
                LX_STAR: begin
                    if (c == "/") st = LX_IDLE;
                    else if (c != "*") st = LX_BLOCK;
                end
                default: idle(c);
            endcase
        endfunction

        // Note one accepted text beat and queue what it should produce.
        function void note_text(logic [7:0] c, logic eot);
            step_q.delete();
            if (eot || c == 0) begin
                put(jtok_pkg::KIND_VERDICT, 0, 0, 0, 0,
                    !halted && (st == LX_IDLE || st == LX_LINE));
                clear();
            end else if (!halted) begin
                lex(c);
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1;
            foreach (step_q[i]) pending_q.push_back(step_q[i]);
        endfunction

        function void check_beat(tok_beat_t got);
            tok_beat_t exp_b;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected beat, expected none actual %h", $time, got);
                errors++;
                return;
            end
            exp_b = pending_q.pop_front();
            if (got !== exp_b) begin
                $display("%0t: mismatch expected %h actual %h", $time, exp_b, got);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n;
    logic        i_cfg_valid, i_cfg_data, o_cfg_ready;
    logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid, m_axis_tready, m_axis_tlast;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    lexer_scoreboard lexsb;
    int          burst_left;

    json_tokenizer_top uut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    // Receiver stall pattern: alternate free-running stretches and random stalls.
    initial begin
        int phase;
        m_axis_tready = 0;
        phase = 0;
        forever begin
            @(posedge i_clk);
            phase++;
            if ((phase / 200) % 2 == 0) m_axis_tready <= 1;
            else m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            lexsb.check_beat('{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[11:4],
                               m_axis_tdata[14:12], m_axis_tdata[15], m_axis_tdata[16],
                               m_axis_tlast});
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            lexsb.note_text(s_axis_tdata, s_axis_tlast);
        if (i_rst_n && i_cfg_valid && o_cfg_ready)
            lexsb.permissive = i_cfg_data;
    end

    // Hold tvalid high across back-to-back beats; drop it only in gaps.
    task automatic send_byte(logic [7:0] c, logic eot);
        if (burst_left == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_axis_tvalid <= 1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
    endtask

    task automatic drain();
        int guard;
        s_axis_tvalid <= 0;
        guard = 0;
        while (lexsb.pending_q.size() != 0 && guard < 10000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        drain();
        i_cfg_valid <= 1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
    endtask

    function automatic logic [7:0] pick_char();
        string alphabet;
        alphabet = "{}[],:\"'\\/*-+.eE0123456789truefalsnlxuabU \n";
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(1, 31));
            default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
        endcase
    endfunction

    function automatic string well_formed();
        string frags[12];
        frags = '{"{\"ab\":12}", "[true,false,null]", "-3.5e+7 ", "\"x\\u00fF\\n\"",
                  "[1.25e9,\"q\\t\"]", "wordy ", "tru ", "{'s':1}", "// c\n",
                  "/* ** */", "nul,", "\"\\q\\uZ\" "};
        return frags[$urandom_range(0, 11)];
    endfunction

    initial begin
        int sent;
        string s;
        lexsb = new();
        lexsb.clear();
        lexsb.permissive = 0;
        lexsb.errors = 0;
        burst_left = 0;
        i_rst_n = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: punctuation, keywords, numbers, escapes, long word, notes.
        send_text("{[]},:true false null -12.5e-3 \"a\\\"\\b\\u0aF9\\x\"");
        send_text("toolongword 1.e 7x");
        send_byte(8'hff, 0);
        send_byte(8'h41, 1);
        write_mode(1);
        send_text("/*a**/'b\\'c'// z");
        send_byte(8'h00, 0);
        send_text("/x");
        send_byte(8'h80, 1);
        write_mode(0);

        sent = 0;
        while (sent < 150) begin
            if ($urandom_range(0, 39) == 0) write_mode($urandom_range(0, 1));
            if ($urandom_range(0, 3) != 0) begin
                s = well_formed();
                send_text(s);
                sent += s.len();
            end else begin
                send_byte(pick_char(), 0);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_byte(pick_char(), 1);
                sent++;
            end
        end
        send_byte(8'h20, 1);
        drain();
        if (lexsb.errors == 0 && lexsb.pending_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
